// ===== rtl/sqlfx_pkg.sv =====
// ---------------------------------------------------------------------------
// sqlfx_pkg: shared types and constants of the session field extractor
// This package holds the byte limit, the field kind codes, the protocol
// constants, and the structs that pass between the top level and the parser.
// ---------------------------------------------------------------------------
package sqlfx_pkg;

	// Leading bytes of a segment that are parsed; range 16 to 4095.
	localparam int MAX_KEPT_BYTES = 255;
	localparam int POS_W = $clog2(MAX_KEPT_BYTES);
	localparam int SEQ_OFFSET = 3;

	// Field kind codes.
	localparam logic [3:0] KIND_VERSION  = 4'd0;
	localparam logic [3:0] KIND_SRV_CAPS = 4'd1;
	localparam logic [3:0] KIND_CLI_CAPS = 4'd2;
	localparam logic [3:0] KIND_EXT_CAPS = 4'd3;
	localparam logic [3:0] KIND_USER     = 4'd4;
	localparam logic [3:0] KIND_DB       = 4'd5;
	localparam logic [3:0] KIND_COMMAND  = 4'd6;
	localparam logic [3:0] KIND_QUERY    = 4'd7;
	localparam logic [3:0] KIND_RESPONSE = 4'd8;

	// Protocol constants.
	localparam logic [15:0] CAP_CONNECT_DB = 16'h0008;
	localparam logic [15:0] CAP_PROTO41    = 16'h0200;
	localparam logic [7:0]  CMD_INIT_DB    = 8'd2;
	localparam logic [7:0]  CMD_QUERY      = 8'd3;
	localparam logic [7:0]  SEQ_FIRST      = 8'd0;
	localparam logic [7:0]  SEQ_SECOND     = 8'd1;
	localparam logic [7:0]  SEQ_THIRD      = 8'd2;
	localparam logic [4:0]  GREET_SKIP     = 5'd13;
	localparam logic [4:0]  LOGIN_SKIP_NEW = 5'd28;
	localparam logic [4:0]  LOGIN_SKIP_OLD = 5'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       from_server;
		logic       export_enable;
	} in_item_t;

	typedef struct packed {
		logic        valid;
		logic [3:0]  kind;
		logic [15:0] value;
		logic        fend;
		logic        done;
	} result_t;

endpackage

// ===== rtl/sqlfx_parser.sv =====
// ---------------------------------------------------------------------------
// sqlfx_parser: per-byte protocol parser
// Holds the parse state of the current segment and, for the byte offered on
// a step, computes the result item and the next state combinationally.
// ---------------------------------------------------------------------------
module sqlfx_parser
	import sqlfx_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	output result_t  res
);

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_IDLE,
		PH_G_PROTO,
		PH_G_VERSION,
		PH_G_SKIP,
		PH_G_CAPS,
		PH_L_CAPS,
		PH_L_EXT,
		PH_L_SKIP,
		PH_L_USER,
		PH_L_PASS,
		PH_L_DB,
		PH_C_CODE,
		PH_C_BODY,
		PH_RESP
	} phase_t;

	phase_t           phase_q, phase_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [7:0]       seq_q, seq_n;
	logic [4:0]       skip_q, skip_n;
	logic [7:0]       low_q, low_n;
	logic [15:0]      caps_q, caps_n;
	logic             ignored_q, ignored_n;

	logic        at_limit;
	logic        final_byte;
	logic        both_caps;
	logic [7:0]  b;
	logic [15:0] word;
	result_t     r;

	assign b          = item.data_byte;
	assign word       = {b, low_q};
	assign at_limit   = (pos_q >= POS_W'(MAX_KEPT_BYTES - 1));
	assign final_byte = item.last_byte || at_limit;
	assign both_caps  = ((caps_q & CAP_PROTO41) != 16'h0000) &&
		((caps_q & CAP_CONNECT_DB) != 16'h0000);

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		seq_n     = seq_q;
		skip_n    = skip_q;
		low_n     = low_q;
		caps_n    = caps_q;
		ignored_n = ignored_q;
		r         = '0;

		if (!ignored_q) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q == POS_W'(SEQ_OFFSET)) begin
						seq_n  = b;
						skip_n = '0;
						if (b == SEQ_FIRST) begin
							phase_n = item.from_server ? PH_G_PROTO : PH_C_CODE;
						end else if (b == SEQ_SECOND) begin
							phase_n = item.from_server ? PH_RESP : PH_L_CAPS;
						end else if (b == SEQ_THIRD && item.from_server) begin
							phase_n = PH_RESP;
						end else begin
							phase_n = PH_IDLE;
						end
					end
				end
				PH_G_PROTO: phase_n = PH_G_VERSION;
				PH_G_VERSION: begin
					r = '{valid: 1'b1, kind: KIND_VERSION, value: {8'h00, b},
						fend: (b == 8'h00) || final_byte, done: 1'b0};
					if (b == 8'h00) begin
						phase_n = PH_G_SKIP;
						skip_n  = GREET_SKIP;
					end
				end
				PH_G_SKIP: begin
					if (skip_q > 5'd1) begin
						skip_n = skip_q - 5'd1;
					end else begin
						skip_n  = '0;
						phase_n = PH_G_CAPS;
					end
				end
				PH_G_CAPS: begin
					if (skip_q == 5'd0) begin
						low_n  = b;
						skip_n = 5'd1;
					end else begin
						skip_n  = '0;
						r = '{valid: 1'b1, kind: KIND_SRV_CAPS, value: word,
							fend: 1'b0, done: 1'b0};
						phase_n = PH_IDLE;
					end
				end
				PH_L_CAPS: begin
					if (skip_q == 5'd0) begin
						low_n  = b;
						skip_n = 5'd1;
					end else begin
						skip_n = '0;
						caps_n = word;
						r = '{valid: 1'b1, kind: KIND_CLI_CAPS, value: word,
							fend: 1'b0, done: 1'b0};
						if ((word & CAP_PROTO41) != 16'h0000) begin
							phase_n = PH_L_EXT;
						end else begin
							phase_n = PH_L_SKIP;
							skip_n  = LOGIN_SKIP_OLD;
						end
					end
				end
				PH_L_EXT: begin
					if (skip_q == 5'd0) begin
						low_n  = b;
						skip_n = 5'd1;
					end else begin
						r = '{valid: 1'b1, kind: KIND_EXT_CAPS, value: word,
							fend: 1'b0, done: 1'b0};
						phase_n = PH_L_SKIP;
						skip_n  = LOGIN_SKIP_NEW;
					end
				end
				PH_L_SKIP: begin
					if (skip_q > 5'd1) begin
						skip_n = skip_q - 5'd1;
					end else begin
						skip_n  = '0;
						phase_n = PH_L_USER;
					end
				end
				PH_L_USER: begin
					r = '{valid: 1'b1, kind: KIND_USER, value: {8'h00, b},
						fend: (b == 8'h00) || final_byte, done: 1'b0};
					if (b == 8'h00) begin
						phase_n = both_caps ? PH_L_PASS : PH_IDLE;
					end
				end
				PH_L_PASS: begin
					if (b == 8'h00) begin
						phase_n = PH_L_DB;
					end
				end
				PH_L_DB: begin
					r = '{valid: 1'b1, kind: KIND_DB, value: {8'h00, b},
						fend: (b == 8'h00) || final_byte, done: 1'b0};
					if (b == 8'h00) begin
						phase_n = PH_IDLE;
					end
				end
				PH_C_CODE: begin
					r = '{valid: 1'b1, kind: KIND_COMMAND, value: {8'h00, b},
						fend: 1'b0, done: 1'b0};
					if (b == CMD_INIT_DB || b == CMD_QUERY) begin
						low_n   = b;
						phase_n = PH_C_BODY;
					end else begin
						phase_n = PH_IDLE;
					end
				end
				PH_C_BODY: begin
					r = '{valid: 1'b1,
						kind: (low_q == CMD_INIT_DB) ? KIND_DB : KIND_QUERY,
						value: {8'h00, b},
						fend: (b == 8'h00) || final_byte, done: 1'b0};
					if (b == 8'h00) begin
						phase_n = PH_IDLE;
					end
				end
				PH_RESP: begin
					r = '{valid: 1'b1, kind: KIND_RESPONSE, value: {8'h00, b},
						fend: 1'b0,
						done: item.export_enable && (seq_q == SEQ_SECOND || both_caps)};
					phase_n = PH_IDLE;
				end
				PH_IDLE: phase_n = PH_IDLE;
				default: phase_n = PH_IDLE;
			endcase

			// A string that would start right after the last kept byte is
			// reported as empty.
			if (!r.valid && final_byte) begin
				if (phase_n == PH_G_VERSION) begin
					r = '{valid: 1'b1, kind: KIND_VERSION, value: 16'h0000,
						fend: 1'b1, done: 1'b0};
				end else if (phase_n == PH_L_USER) begin
					r = '{valid: 1'b1, kind: KIND_USER, value: 16'h0000,
						fend: 1'b1, done: 1'b0};
				end else if (phase_n == PH_L_DB) begin
					r = '{valid: 1'b1, kind: KIND_DB, value: 16'h0000,
						fend: 1'b1, done: 1'b0};
				end
			end

			if (at_limit) begin
				ignored_n = 1'b1;
			end else begin
				pos_n = pos_q + POS_W'(1);
			end
		end

		if (item.last_byte) begin
			pos_n     = '0;
			phase_n   = PH_HEADER;
			skip_n    = '0;
			ignored_n = 1'b0;
		end
	end

	assign res = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= '0;
			seq_q     <= '0;
			skip_q    <= '0;
			low_q     <= '0;
			caps_q    <= '0;
			ignored_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			seq_q     <= seq_n;
			skip_q    <= skip_n;
			low_q     <= low_n;
			caps_q    <= caps_n;
			ignored_q <= ignored_n;
		end
	end

endmodule

// ===== rtl/sql_session_field_extractor_unit.sv =====
// ---------------------------------------------------------------------------
// sql_session_field_extractor_unit: session field extractor top level
// Registers each input byte, parses it against the segment state, and holds
// the resulting field item in an output register until it is taken.
// ---------------------------------------------------------------------------
// Path: the input register takes the byte at its transfer, and the output
// register takes the result when the parser steps on that byte; a stalled
// output holds the byte in the input register. The parser is combinational.
// Throughput: one byte per cycle unless a waiting result stalls the output.
// Reset: arst_n clears the parse state, the captured client capabilities and
// both valid flags; the block is ready for bytes as soon as reset is released.
module sql_session_field_extractor_unit
	import sqlfx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        from_server,
	input  logic        export_enable,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  field_kind,
	output logic [15:0] field_value,
	output logic        field_end,
	output logic        record_done
);

	logic     valid_s1;
	in_item_t item_s1;
	logic     advance;
	result_t  res;
	logic     out_valid_q;
	result_t  out_q;

	// The registered byte moves on once the output register is free or emptying.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{data_byte: data_byte, last_byte: last_byte,
				from_server: from_server, export_enable: export_enable};
		end
	end

	sqlfx_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign field_kind  = out_q.kind;
	assign field_value = out_q.value;
	assign field_end   = out_q.fend;
	assign record_done = out_q.done;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register changed while its byte was stalled");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !advance)
		else $error("parser stepped while a result was still waiting");

	a_end_on_string: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.fend |-> out_q.kind == KIND_VERSION ||
		out_q.kind == KIND_USER || out_q.kind == KIND_DB || out_q.kind == KIND_QUERY)
		else $error("string end mark on a non-string field");

	a_done_on_resp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.done |-> out_q.kind == KIND_RESPONSE)
		else $error("record done mark on a field other than a response");

endmodule

// ===== tb/sql_session_field_extractor_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sql_session_field_extractor_unit_tb: self-checking bench for the extractor
// A short table of hand-written segments is followed by random greeting,
// login, command, response and junk segments. A byte-level model of the
// parser predicts each field item (typed table rows give their own), and each
// output transfer is compared with the oldest prediction.
// ---------------------------------------------------------------------------
module sql_session_field_extractor_unit_tb;
	import sqlfx_pkg::*;

	localparam int BYTE_TARGET = 1250;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 200;
	localparam int SEG_LONG_QUERY = 5;
	localparam int SEG_LONG_GREET = 15;
	localparam int SEG_RX_HOLD = 8;
	localparam int SEG_DRAIN = 20;

	typedef enum logic [3:0] {
		S_HEADER, S_IDLE, S_G_PROTO, S_G_VERSION, S_G_SKIP, S_G_CAPS,
		S_L_CAPS, S_L_EXT, S_L_SKIP, S_L_USER, S_L_PASS, S_L_DB,
		S_C_CODE, S_C_BODY, S_RESP
	} step_t;

	typedef enum int {
		SEG_GREETING, SEG_LOGIN, SEG_COMMAND, SEG_RESPONSE, SEG_JUNK
	} seg_kind_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] value;
		logic        fend;
		logic        done;
	} field_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       srv;
		logic       ex;
		logic       typed;
		field_t     want;
	} row_t;

	// Hand-written segments; rows marked typed carry the field item expected.
	localparam row_t DIRECTED [0:24] = '{
		// Four-byte segment: too short to give anything.
		'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, '0},
		// Query command whose text is cut off after one character.
		'{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0},
		'{8'h03, 1'b0, 1'b0, 1'b0, 1'b1, '{KIND_COMMAND, 16'h0003, 1'b0, 1'b0}},
		'{8'h41, 1'b1, 1'b0, 1'b0, 1'b1, '{KIND_QUERY, 16'h0041, 1'b1, 1'b0}},
		// Exported response on the second sequence number.
		'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b1, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, '{KIND_RESPONSE, 16'h00FF, 1'b0, 1'b1}},
		// Greeting that ends just before its version string.
		'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
		'{8'h0A, 1'b1, 1'b1, 1'b0, 1'b1, '{KIND_VERSION, 16'h0000, 1'b1, 1'b0}},
		// Init-db command whose code is the final byte.
		'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0},
		'{8'h02, 1'b1, 1'b0, 1'b0, 1'b1, '{KIND_COMMAND, 16'h0002, 1'b0, 1'b0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        from_server = 1'b0;
	logic        export_enable = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  field_kind;
	logic [15:0] field_value;
	logic        field_end;
	logic        record_done;

	sql_session_field_extractor_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.from_server   (from_server),
		.export_enable (export_enable),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.field_kind    (field_kind),
		.field_value   (field_value),
		.field_end     (field_end),
		.record_done   (record_done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Parser state as the model of the block sees it.
	int          seg_pos;
	step_t       parse_step;
	logic [7:0]  seq_no;
	logic [4:0]  skip_left;
	logic [7:0]  held_byte;
	logic [15:0] cli_caps;
	bit          past_limit;

	field_t      fields_due[$];
	logic [7:0]  seg_bytes[$];
	bit          seg_srv;
	bit          tx_calm;
	bit          rx_calm;
	bit          hold_request;
	int          errors;
	int          bytes_sent;
	int          fields_checked;
	int          segments_sent;
	int          cycle_count;

	function automatic bit both_caps_set();
		return ((cli_caps & CAP_PROTO41) != 0) && ((cli_caps & CAP_CONNECT_DB) != 0);
	endfunction

	function automatic bit take_char(input logic [3:0] kind, input logic [7:0] b,
			input logic fin, input step_t nxt, output field_t f);
		if (b == 8'h00) begin
			parse_step = nxt;
			f = '{kind, 16'h0000, 1'b1, 1'b0};
		end else begin
			f = '{kind, {8'h00, b}, fin, 1'b0};
		end
		return 1'b1;
	endfunction

	function automatic bit skip_finished();
		if (skip_left > 5'd1) begin
			skip_left = skip_left - 5'd1;
			return 1'b0;
		end
		skip_left = 5'd0;
		return 1'b1;
	endfunction

	// A word arrives low byte first; skip_left tells which half is due.
	function automatic bit word_complete(input logic [7:0] b, output logic [15:0] w);
		w = '0;
		if (skip_left == 5'd0) begin
			held_byte = b;
			skip_left = 5'd1;
			return 1'b0;
		end
		skip_left = 5'd0;
		w = {b, held_byte};
		return 1'b1;
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, input logic srv, ex, fin,
			output field_t f);
		logic [15:0] w;
		bit          got;
		got = 1'b0;
		f = '0;
		case (parse_step)
			S_HEADER: begin
				if (seg_pos == SEQ_OFFSET) begin
					seq_no = b;
					skip_left = 5'd0;
					if (b == SEQ_FIRST)
						parse_step = srv ? S_G_PROTO : S_C_CODE;
					else if (b == SEQ_SECOND)
						parse_step = srv ? S_RESP : S_L_CAPS;
					else if (b == SEQ_THIRD && srv)
						parse_step = S_RESP;
					else
						parse_step = S_IDLE;
				end
			end
			S_G_PROTO: parse_step = S_G_VERSION;
			S_G_VERSION: begin
				got = take_char(KIND_VERSION, b, fin, S_G_SKIP, f);
				if (parse_step == S_G_SKIP)
					skip_left = GREET_SKIP;
			end
			S_G_SKIP: begin
				if (skip_finished())
					parse_step = S_G_CAPS;
			end
			S_G_CAPS: begin
				if (word_complete(b, w)) begin
					got = 1'b1;
					f = '{KIND_SRV_CAPS, w, 1'b0, 1'b0};
					parse_step = S_IDLE;
				end
			end
			S_L_CAPS: begin
				if (word_complete(b, w)) begin
					cli_caps = w;
					got = 1'b1;
					f = '{KIND_CLI_CAPS, w, 1'b0, 1'b0};
					if ((w & CAP_PROTO41) != 0) begin
						parse_step = S_L_EXT;
					end else begin
						parse_step = S_L_SKIP;
						skip_left = LOGIN_SKIP_OLD;
					end
				end
			end
			S_L_EXT: begin
				if (word_complete(b, w)) begin
					got = 1'b1;
					f = '{KIND_EXT_CAPS, w, 1'b0, 1'b0};
					parse_step = S_L_SKIP;
					skip_left = LOGIN_SKIP_NEW;
				end
			end
			S_L_SKIP: begin
				if (skip_finished())
					parse_step = S_L_USER;
			end
			S_L_USER: got = take_char(KIND_USER, b, fin,
					both_caps_set() ? S_L_PASS : S_IDLE, f);
			S_L_PASS: begin
				if (b == 8'h00)
					parse_step = S_L_DB;
			end
			S_L_DB: got = take_char(KIND_DB, b, fin, S_IDLE, f);
			S_C_CODE: begin
				got = 1'b1;
				f = '{KIND_COMMAND, {8'h00, b}, 1'b0, 1'b0};
				if (b == CMD_INIT_DB || b == CMD_QUERY) begin
					held_byte = b;
					parse_step = S_C_BODY;
				end else begin
					parse_step = S_IDLE;
				end
			end
			S_C_BODY: got = take_char((held_byte == CMD_INIT_DB) ? KIND_DB : KIND_QUERY,
					b, fin, S_IDLE, f);
			S_RESP: begin
				got = 1'b1;
				f = '{KIND_RESPONSE, {8'h00, b}, 1'b0,
					ex && (seq_no == SEQ_SECOND || both_caps_set())};
				parse_step = S_IDLE;
			end
			default: parse_step = S_IDLE;
		endcase
		// A string that was due to start when the kept bytes ran out is reported empty.
		if (!got && fin) begin
			case (parse_step)
				S_G_VERSION: begin
					got = 1'b1;
					f = '{KIND_VERSION, 16'h0000, 1'b1, 1'b0};
				end
				S_L_USER: begin
					got = 1'b1;
					f = '{KIND_USER, 16'h0000, 1'b1, 1'b0};
				end
				S_L_DB: begin
					got = 1'b1;
					f = '{KIND_DB, 16'h0000, 1'b1, 1'b0};
				end
				default: ;
			endcase
		end
		return got;
	endfunction

	function automatic bit predict_field(input logic [7:0] b, input logic last, srv, ex,
			output field_t f);
		bit got;
		bit at_limit;
		got = 1'b0;
		f = '0;
		if (!past_limit) begin
			at_limit = (seg_pos >= MAX_KEPT_BYTES - 1);
			got = parse_byte(b, srv, ex, last || at_limit, f);
			if (at_limit)
				past_limit = 1'b1;
			else
				seg_pos++;
		end
		if (last) begin
			seg_pos = 0;
			parse_step = S_HEADER;
			skip_left = 5'd0;
			past_limit = 1'b0;
		end
		return got;
	endfunction

	// Offers one byte after a random gap (none while tx_calm is set) and records the field it should cause, if any.
	task automatic send_byte(input logic [7:0] d, input logic l, s, e,
			input logic typed, input field_t want);
		int     gap;
		field_t f;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		from_server <= s;
		export_enable <= e;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		if (predict_field(d, l, s, e, f))
			fields_due.push_back(typed ? want : f);
	endtask

	task automatic put_random(input int n);
		repeat (n) seg_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic put_string(input int n);
		repeat (n) seg_bytes.push_back(8'($urandom_range(1, 255)));
		seg_bytes.push_back(8'h00);
	endtask

	task automatic put_header(input logic [7:0] seq);
		put_random(3);
		seg_bytes.push_back(seq);
	endtask

	task automatic build_segment(input seg_kind_t kind, input int long_len);
		logic [15:0] caps;
		logic [7:0]  code;
		int          pick;
		seg_bytes.delete();
		case (kind)
			SEG_GREETING: begin
				seg_srv = 1'b1;
				put_header(SEQ_FIRST);
				put_random(1);
				put_string(long_len > 0 ? long_len : $urandom_range(0, 12));
				put_random(GREET_SKIP + 2);
			end
			SEG_LOGIN: begin
				seg_srv = 1'b0;
				put_header(SEQ_SECOND);
				caps = 16'($urandom_range(0, 65535));
				caps = ($urandom_range(0, 3) != 0) ? (caps | CAP_PROTO41) : (caps & ~CAP_PROTO41);
				caps = ($urandom_range(0, 3) != 0) ? (caps | CAP_CONNECT_DB)
					: (caps & ~CAP_CONNECT_DB);
				seg_bytes.push_back(caps[7:0]);
				seg_bytes.push_back(caps[15:8]);
				if ((caps & CAP_PROTO41) != 0)
					put_random(2 + LOGIN_SKIP_NEW);
				else
					put_random(LOGIN_SKIP_OLD);
				put_string($urandom_range(0, 10));
				if ((caps & CAP_PROTO41) != 0 && (caps & CAP_CONNECT_DB) != 0) begin
					put_string($urandom_range(0, 8));
					put_string($urandom_range(0, 10));
				end
			end
			SEG_COMMAND: begin
				seg_srv = 1'b0;
				put_header(SEQ_FIRST);
				pick = $urandom_range(0, 3);
				if (long_len > 0 || pick == 1 || pick == 2)
					code = CMD_QUERY;
				else if (pick == 0)
					code = CMD_INIT_DB;
				else
					code = 8'($urandom_range(0, 255));
				seg_bytes.push_back(code);
				if (code == CMD_INIT_DB || code == CMD_QUERY)
					put_string(long_len > 0 ? long_len : $urandom_range(0, 16));
			end
			SEG_RESPONSE: begin
				seg_srv = 1'b1;
				put_header($urandom_range(0, 1) ? SEQ_SECOND : SEQ_THIRD);
				put_random(1);
			end
			default: begin
				seg_srv = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 1))
					put_header(8'($urandom_range(0, 3)));
				else
					put_header(8'($urandom_range(0, 255)));
				put_random($urandom_range(0, 12));
			end
		endcase
		if (long_len == 0) begin
			if ($urandom_range(0, 1))
				put_random($urandom_range(1, 3));
			if ($urandom_range(0, 4) == 0)
				seg_bytes = seg_bytes[0:$urandom_range(0, seg_bytes.size() - 1)];
		end
	endtask

	// Only the direction on the sequence byte matters; the others are scrambled.
	task automatic send_segment();
		logic s;
		for (int i = 0; i < seg_bytes.size(); i++) begin
			s = (i == SEQ_OFFSET) ? seg_srv : 1'($urandom_range(0, 1));
			send_byte(seg_bytes[i], i == seg_bytes.size() - 1, s,
				1'($urandom_range(0, 1)), 1'b0, '0);
		end
		segments_sent++;
	endtask

	task automatic check_field();
		field_t want;
		if (fields_due.size() == 0) begin
			errors++;
			$display("%0t: unexpected field: kind %0d value %h end %b done %b", $time,
				field_kind, field_value, field_end, record_done);
		end else begin
			want = fields_due.pop_front();
			fields_checked++;
			if (field_kind !== want.kind) begin
				errors++;
				$display("%0t: field_kind expected %0d got %0d", $time, want.kind, field_kind);
			end
			if (field_value !== want.value) begin
				errors++;
				$display("%0t: field_value expected %h got %h", $time, want.value,
					field_value);
			end
			if (field_end !== want.fend) begin
				errors++;
				$display("%0t: field_end expected %b got %b", $time, want.fend, field_end);
			end
			if (record_done !== want.done) begin
				errors++;
				$display("%0t: record_done expected %b got %b", $time, want.done,
					record_done);
			end
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d fields still due", cycle_count,
				fields_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: random stalls per transfer, plus one long hold on request.
	initial begin
		int gap;
		rx_calm = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			if ($urandom_range(0, 31) == 0)
				rx_calm = !rx_calm;
			gap = rx_calm ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_field();
		end
	end

	initial begin
		seg_kind_t kind;
		int        pick;
		errors = 0;
		bytes_sent = 0;
		fields_checked = 0;
		segments_sent = 0;
		cycle_count = 0;
		hold_request = 1'b0;
		tx_calm = 1'b0;
		seg_pos = 0;
		parse_step = S_HEADER;
		seq_no = 8'h00;
		skip_left = 5'd0;
		held_byte = 8'h00;
		cli_caps = 16'h0000;
		past_limit = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].srv, DIRECTED[i].ex,
				DIRECTED[i].typed, DIRECTED[i].want);

		while (bytes_sent < BYTE_TARGET) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			if (segments_sent == SEG_RX_HOLD)
				hold_request = 1'b1;
			if (segments_sent == SEG_DRAIN) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (fields_due.size() != 0);
			end
			if (segments_sent == SEG_LONG_QUERY) begin
				build_segment(SEG_COMMAND, 260);
			end else if (segments_sent == SEG_LONG_GREET) begin
				build_segment(SEG_GREETING, 260);
			end else begin
				pick = $urandom_range(0, 8);
				case (pick)
					0, 1: kind = SEG_GREETING;
					2, 3: kind = SEG_LOGIN;
					4, 5: kind = SEG_COMMAND;
					6, 7: kind = SEG_RESPONSE;
					default: kind = SEG_JUNK;
				endcase
				build_segment(kind, 0);
			end
			send_segment();
		end
		in_valid <= 1'b0;

		while (fields_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fields_due.size() != 0)
			errors++;

		$display("sent %0d segments (%0d bytes) of every message type, junk and over-limit",
			segments_sent, bytes_sent);
		$display("checked %0d field transfers across random stalls and one long hold",
			fields_checked);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
